// ----- rtl/csid_pkg.sv -----
// Shared types and constants for the indexed-insert byte stack.
`default_nettype none

package csid_pkg;

  // Stack geometry and field widths
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned KeyW  = 8;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned PosW  = 5;
  localparam int unsigned StatW = 3;

  // Command codes
  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Status codes
  localparam logic [StatW-1:0] STATUS_OK       = 3'd0;
  localparam logic [StatW-1:0] STATUS_EMPTY    = 3'd1;
  localparam logic [StatW-1:0] STATUS_NOTFOUND = 3'd2;
  localparam logic [StatW-1:0] STATUS_FULL     = 3'd3;
  localparam logic [StatW-1:0] STATUS_BEYOND   = 3'd4;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  // Input item
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key_in;
    logic [PosW-1:0] position;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [KeyW-1:0]  key_out;
    logic [CntW-1:0]  count;
    logic             last;
  } out_item_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot and write the key
    logic del;  // close the gap from the first match down
    logic rot;  // rotate live entries up by one (dump)
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/char_stack_indexed_insert_delete_top.sv -----
// Indexed-insert byte stack: a row of shifting cells under a small controller.
// Insert, delete, unused codes and a dump of an empty stack each give one result item.
// A dump gives one item per entry, one per cycle while the output slot can move, top first, rotating the row.
// A new item is taken each cycle while not dumping and the output slot can move.
// Reset clears the count, state, dump index and output valid; cell contents are undefined.
`default_nettype none

module char_stack_indexed_insert_delete_top (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire  csid_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output csid_pkg::out_item_t    out_item_o
);
  import csid_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] dump_idx_q, dump_idx_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;

  cell_ctrl_t      ctrl;
  logic            out_free;
  logic            accept;
  logic            emit;

  logic [KeyW-1:0] cell_data [DEPTH];
  logic            hit_chain [DEPTH+1];

  // Command decode
  logic            full, empty, beyond, found, dump_last;
  logic [PosW-1:0] ins_depth;
  logic [IdxW-1:0] ins_idx;

  assign full      = (count_q == CntW'(DEPTH));
  assign empty     = (count_q == '0);
  assign ins_depth = (empty || (in_item_i.position <= PosW'(1)))
                     ? '0 : (in_item_i.position - PosW'(1));
  assign beyond    = (ins_depth > PosW'(count_q));
  assign ins_idx   = ins_depth[IdxW-1:0];
  assign found     = hit_chain[DEPTH];
  assign dump_last = ((CntW'(dump_idx_q) + CntW'(1)) == count_q);

  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  // Cell row
  assign hit_chain[0] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KeyW-1:0] above, below;
    if (g == 0) begin : g_top
      assign above = cell_data[0];
    end else begin : g_mid_a
      assign above = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_bot
      assign below = cell_data[g];
    end else begin : g_mid_b
      assign below = cell_data[g+1];
    end

    csid_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (IdxW'(g)),
      .ctrl_i    (ctrl),
      .key_i     (in_item_i.key_in),
      .ins_idx_i (ins_idx),
      .count_i   (count_q),
      .above_i   (above),
      .below_i   (below),
      .wrap_i    (cell_data[0]),
      .hit_i     (hit_chain[g]),
      .hit_o     (hit_chain[g+1]),
      .data_o    (cell_data[g])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (in_item_i.cmd == CMD_DUMP) && !empty) begin
          state_d = S_DUMP;
        end
      end
      S_DUMP: begin
        if (out_free && dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Controller outputs and datapath updates
  always_comb begin
    in_ready_o = 1'b0;
    emit       = 1'b0;
    ctrl       = '0;
    count_d    = count_q;
    dump_idx_d = dump_idx_q;
    out_d      = out_q;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = out_free;
        if (accept) begin
          out_d.key_out = '0;
          out_d.last    = 1'b1;
          out_d.count   = count_q;
          out_d.status  = STATUS_OK;
          emit          = 1'b1;
          unique case (in_item_i.cmd)
            CMD_INSERT: begin
              if (full) begin
                out_d.status = STATUS_FULL;
              end else if (beyond) begin
                out_d.status = STATUS_BEYOND;
              end else begin
                ctrl.ins    = 1'b1;
                count_d     = count_q + CntW'(1);
                out_d.count = count_q + CntW'(1);
              end
            end
            CMD_DELETE: begin
              if (empty) begin
                out_d.status = STATUS_EMPTY;
              end else if (!found) begin
                out_d.status = STATUS_NOTFOUND;
              end else begin
                ctrl.del    = 1'b1;
                count_d     = count_q - CntW'(1);
                out_d.count = count_q - CntW'(1);
              end
            end
            CMD_DUMP: begin
              if (empty) begin
                out_d.status = STATUS_EMPTY;
              end else begin
                emit       = 1'b0;
                dump_idx_d = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit          = 1'b1;
          ctrl.rot      = 1'b1;
          out_d.status  = STATUS_OK;
          out_d.key_out = cell_data[0];
          out_d.count   = count_q;
          out_d.last    = dump_last;
          dump_idx_d    = dump_idx_q + IdxW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output valid
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      dump_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      dump_idx_q  <= dump_idx_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/csid_cell.sv -----
// One stack cell: holds an entry, compares it, and shifts with its neighbors.
`default_nettype none

module csid_cell (
  input  wire                             clk_i,
  input  wire  [csid_pkg::IdxW-1:0]       idx_i,
  input  wire  csid_pkg::cell_ctrl_t      ctrl_i,
  input  wire  [csid_pkg::KeyW-1:0]       key_i,
  input  wire  [csid_pkg::IdxW-1:0]       ins_idx_i,
  input  wire  [csid_pkg::CntW-1:0]       count_i,
  input  wire  [csid_pkg::KeyW-1:0]       above_i,
  input  wire  [csid_pkg::KeyW-1:0]       below_i,
  input  wire  [csid_pkg::KeyW-1:0]       wrap_i,
  input  wire                             hit_i,
  output logic                            hit_o,
  output logic [csid_pkg::KeyW-1:0]       data_o
);
  import csid_pkg::*;

  logic [KeyW-1:0] data_q, data_d;
  logic            live;
  logic            is_tail;

  // Cell lies inside the stack, and is the bottom live cell
  assign live    = ({1'b0, idx_i} < count_i);
  assign is_tail = ((CntW'(idx_i) + CntW'(1)) == count_i);

  // First-match chain from the top
  assign hit_o = hit_i | (live && (data_q == key_i));

  // Next entry
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx_i == ins_idx_i) begin
        data_d = key_i;
      end else if (idx_i > ins_idx_i) begin
        data_d = above_i;
      end
    end else if (ctrl_i.del) begin
      if (hit_o) begin
        data_d = below_i;
      end
    end else if (ctrl_i.rot) begin
      data_d = is_tail ? wrap_i : below_i;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the indexed-insert byte stack: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_top;
  import csid_pkg::*;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned RAND_ITEMS     = 480;
  localparam int unsigned SEG_ITEMS      = 60;    // items per idling segment
  localparam int unsigned BIAS_ITEMS     = 40;    // items per fill/drain bias segment
  localparam int unsigned HOLD_AT        = 130;   // random item that starts the long output hold
  localparam int unsigned DRAIN_AT       = 300;   // random item before which the sender waits
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_TX,
    IDLE_RX,
    IDLE_BOTH
  } idle_mode_e;

  // One row of the directed table; typed rows carry their single expected result
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni;
  logic      in_valid_i  = 1'b0;
  logic      out_ready_i = 1'b0;
  in_item_t  in_item_i   = '0;
  logic      in_ready_o;
  logic      out_valid_o;
  out_item_t out_item_o;

  // Side info travelling with the offered item
  bit        drv_typed = 1'b0;
  out_item_t drv_res   = '0;

  idle_mode_e idle_mode = IDLE_BOTH;
  bit         hold_req  = 1'b0;
  bit         hold_done = 1'b0;
  int         hold_cnt  = 0;
  int         quiet_cycles = 0;
  int         fail_cnt = 0;

  // Shadow stack: cell 0 is the top
  logic [KeyW-1:0] stk_cells [DEPTH];
  int unsigned     stk_count = 0;

  out_item_t step_results[$];
  out_item_t expected_results[$];
  dir_row_t  dir_rows[$];

  char_stack_indexed_insert_delete_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Work out the results of one accepted command and update the shadow stack
  task automatic stack_predict(input in_item_t it);
    out_item_t   pred;
    int unsigned d;
    bit          found;
    pred = '0;
    pred.last = 1'b1;
    case (cmd_e'(it.cmd))
      CMD_INSERT: begin
        if (stk_count >= DEPTH) begin
          pred.status = STATUS_FULL;
        end else begin
          if (stk_count == 0 || it.position <= 1) d = 0;
          else d = it.position - 1;
          if (d > stk_count) begin
            pred.status = STATUS_BEYOND;
          end else begin
            for (int i = stk_count; i > d; i--) stk_cells[i] = stk_cells[i-1];
            stk_cells[d] = it.key_in;
            stk_count++;
            pred.status = STATUS_OK;
          end
        end
        pred.count = CntW'(stk_count);
        step_results.push_back(pred);
      end
      CMD_DELETE: begin
        found = 1'b0;
        if (stk_count == 0) begin
          pred.status = STATUS_EMPTY;
        end else begin
          for (int i = 0; i < stk_count; i++) begin
            if (!found && stk_cells[i] == it.key_in) begin
              for (int j = i; j + 1 < stk_count; j++) stk_cells[j] = stk_cells[j+1];
              stk_count--;
              found = 1'b1;
            end
          end
          pred.status = found ? STATUS_OK : STATUS_NOTFOUND;
        end
        pred.count = CntW'(stk_count);
        step_results.push_back(pred);
      end
      CMD_DUMP: begin
        if (stk_count == 0) begin
          pred.status = STATUS_EMPTY;
          step_results.push_back(pred);
        end else begin
          for (int i = 0; i < stk_count; i++) begin
            pred.status  = STATUS_OK;
            pred.key_out = stk_cells[i];
            pred.count   = CntW'(stk_count);
            pred.last    = (i + 1 == stk_count);
            step_results.push_back(pred);
          end
        end
      end
      default: begin
        pred.status = STATUS_OK;
        pred.count  = CntW'(stk_count);
        step_results.push_back(pred);
      end
    endcase
  endtask

  task automatic report_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic add_row(input cmd_e cmd, input logic [KeyW-1:0] key,
                         input logic [PosW-1:0] pos);
    dir_row_t row;
    row.item.cmd      = cmd;
    row.item.key_in   = key;
    row.item.position = pos;
    row.typed         = 1'b0;
    row.res           = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_typed(input cmd_e cmd, input logic [KeyW-1:0] key,
                           input logic [PosW-1:0] pos, input logic [StatW-1:0] st,
                           input int cnt);
    dir_row_t row;
    row.item.cmd      = cmd;
    row.item.key_in   = key;
    row.item.position = pos;
    row.typed         = 1'b1;
    row.res.status    = st;
    row.res.key_out   = '0;
    row.res.count     = CntW'(cnt);
    row.res.last      = 1'b1;
    dir_rows.push_back(row);
  endtask

  function automatic bit tx_idle_now();
    case (idle_mode)
      IDLE_TX:   return $urandom_range(0, 99) < 86;
      IDLE_BOTH: return $urandom_range(0, 99) < 22;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit rx_stall_now();
    case (idle_mode)
      IDLE_RX:   return $urandom_range(0, 99) < 86;
      IDLE_BOTH: return $urandom_range(0, 99) < 22;
      default:   return 1'b0;
    endcase
  endfunction

  // Random command shaped by the shadow stack; fill_bias favors inserts
  function automatic in_item_t pick_item(input bit fill_bias);
    in_item_t    it;
    int unsigned roll;
    int unsigned n;
    n = stk_count;
    roll = $urandom_range(0, 99);
    it.key_in   = ($urandom_range(0, 3) == 0) ? KeyW'($urandom_range(0, 7))
                                              : KeyW'($urandom_range(0, 255));
    it.position = PosW'($urandom_range(0, 31));
    if (roll < 3) begin
      it.cmd = CMD_NOP;
    end else if (roll < 13) begin
      it.cmd = CMD_DUMP;
    end else if (roll < (fill_bias ? 78 : 43)) begin
      it.cmd = CMD_INSERT;
      roll = $urandom_range(0, 9);
      if (roll < 8) it.position = PosW'($urandom_range(0, n + 1));
      else if (roll < 9) it.position = PosW'($urandom_range(n + 2, 31));
    end else begin
      it.cmd = CMD_DELETE;
      roll = $urandom_range(0, 9);
      if (n > 0 && roll < 6) it.key_in = stk_cells[$urandom_range(0, n - 1)];
    end
    return it;
  endfunction

  // Offer one item and wait for it to be taken
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t res);
    if (tx_idle_now()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (tx_idle_now()) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    drv_typed  <= typed;
    drv_res    <= res;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Output side: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done   <= 1'b1;
      hold_cnt    <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= !rx_stall_now();
    end
  end

  // Predict on input accept, check on output accept
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        step_results.delete();
        stack_predict(in_item_i);
        if (drv_typed) expected_results.push_back(drv_res);
        else foreach (step_results[i]) expected_results.push_back(step_results[i]);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_fail($sformatf("unexpected result: status %0d key %02h count %0d last %0d",
                                out_item_o.status, out_item_o.key_out, out_item_o.count,
                                out_item_o.last));
        end else begin
          want = expected_results.pop_front();
          if (out_item_o.status !== want.status || out_item_o.key_out !== want.key_out ||
              out_item_o.count !== want.count || out_item_o.last !== want.last) begin
            report_fail($sformatf({"result mismatch: expected status %0d key %02h count %0d ",
                                   "last %0d, got status %0d key %02h count %0d last %0d"},
                                  want.status, want.key_out, want.count, want.last,
                                  out_item_o.status, out_item_o.key_out, out_item_o.count,
                                  out_item_o.last));
          end
        end
      end
    end
  end

  // Watchdog: cycles in which no item moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : driver
    // Assert reset with a real falling edge so the asynchronous reset fires
    rst_ni <= 1'b0;

    // Directed table
    add_typed(CMD_DUMP,   8'h00, 5'd0,  STATUS_EMPTY, 0);
    add_typed(CMD_DELETE, 8'h00, 5'd0,  STATUS_EMPTY, 0);
    // empty stack: top whatever the position
    add_typed(CMD_INSERT, 8'hFF, 5'd31, STATUS_OK, 1);
    add_typed(CMD_INSERT, 8'h00, 5'd0,  STATUS_OK, 2);
    add_typed(CMD_INSERT, 8'h5A, 5'd1,  STATUS_OK, 3);
    add_typed(CMD_INSERT, 8'hA5, 5'd5,  STATUS_BEYOND, 3);
    add_row(CMD_INSERT, 8'h11, 5'd4);   // append at the bottom
    add_row(CMD_INSERT, 8'h22, 5'd3);
    add_row(CMD_DUMP,   8'h00, 5'd0);
    add_typed(CMD_DELETE, 8'h77, 5'd0,  STATUS_NOTFOUND, 5);
    add_row(CMD_DELETE, 8'h5A, 5'd0);
    add_typed(CMD_NOP,    8'hFF, 5'd31, STATUS_OK, 4);
    for (int i = 0; i < 11; i++) add_row(CMD_INSERT, KeyW'(8'h30 + i), PosW'(i % 4 + 2));
    add_typed(CMD_INSERT, 8'hC3, 5'd16, STATUS_OK, 16);
    // full is checked before the position
    add_typed(CMD_INSERT, 8'h3C, 5'd1,  STATUS_FULL, 16);
    add_row(CMD_DUMP,   8'h00, 5'd0);
    add_row(CMD_DELETE, 8'hC3, 5'd0);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_mode = IDLE_BOTH;
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    // Random traffic, idling mode and fill bias change by segment
    for (int k = 0; k < RAND_ITEMS; k++) begin
      idle_mode = idle_mode_e'((k / SEG_ITEMS) % 4);
      if (k == HOLD_AT) hold_req <= 1'b1;
      if (k == DRAIN_AT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (expected_results.size() != 0) @(posedge clk_i);
      end
      send_item(pick_item((k / BIAS_ITEMS) % 2 == 0), 1'b0, '0);
    end

    // Drain and let the block settle
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_fail($sformatf("%0d results never arrived", expected_results.size()));

    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
